// File: rtl/qrd_pkg.sv
// Package for the quote reprice decider: word types, field widths,
// action codes and configuration register indexes.
// No dependencies; imported by every module of the block.
package qrd_pkg;

    // Field widths fixed by the word formats.
    localparam int PRICE_W = 48;
    localparam int FLOW_W  = 16;
    localparam int ID_W    = 48;
    localparam int TICK_W  = 32;
    localparam int Q88_W   = 16;
    localparam int ACT_W   = 2;

    // Shared multiplier operand and product widths.
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // Action codes carried in action_kind.
    localparam logic [ACT_W-1:0] ACT_NONE    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_NEW     = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REPLACE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_SIZE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_SPREAD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SKEW      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPRICE_THR   = 3'd4;

    // Market update word.
    typedef struct packed {
        logic signed [PRICE_W-1:0] mid_price;
        logic signed [FLOW_W-1:0]  flow_imbalance;
    } upd_word_t;

    // Quote action word.
    typedef struct packed {
        logic [ACT_W-1:0]          action_kind;
        logic signed [PRICE_W-1:0] bid_price_out;
        logic signed [PRICE_W-1:0] ask_price_out;
        logic [ID_W-1:0]           cancelled_bid_id;
        logic [ID_W-1:0]           cancelled_ask_id;
        logic [ID_W-1:0]           fresh_bid_id;
        logic [ID_W-1:0]           fresh_ask_id;
    } quote_word_t;

endpackage

// File: rtl/qrd_mul.sv
// Shared unsigned 32 x 32 multiplier with a registered product.
// Depends on qrd_pkg for the operand and product widths.
module qrd_mul
(
    input  logic                        clk,
    input  logic [qrd_pkg::MUL_W-1:0]   op_a,
    input  logic [qrd_pkg::MUL_W-1:0]   op_b,
    output logic [qrd_pkg::PROD_W-1:0]  prod
);
    import qrd_pkg::*;

    logic [PROD_W-1:0] prod_reg;

    // One product per cycle, ready the cycle after the operands.
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

// File: rtl/quote_reprice_decider_unit.sv
// Top level of the quote reprice decider: configuration registers, the
// sequencer around the shared multiplier, held quote state and output register.
// Depends on qrd_pkg and qrd_mul.
//
//  channel  | signals                          | direction | handshake
//  ---------+----------------------------------+-----------+-----------------
//  upd      | upd_valid upd_stall upd_word     | in        | valid & !stall
//  quote    | quote_valid quote_stall quote_word | out     | valid & !stall
//  cfg      | cfg_valid cfg_ready cfg_index cfg_data | in  | valid & ready
//
// Each update takes four passes through the one shared multiplier, a sum
// and a finish step, then an idle state to take the next update; a new update
// is not taken before the last one finishes. The quote word is loaded into the
// output register as the finish step completes.
// Reset is asynchronous, active low; it loads the register defaults and
// clears the held quote, with the id counter at one.
// A stalled quote word holds the finish step until the output register frees.
module quote_reprice_decider_unit
#(
    parameter int ID_BITS         = 48,
    parameter int PRICE_FRAC_BITS = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              upd_valid,
    output logic                              upd_stall,
    input  qrd_pkg::upd_word_t                upd_word,
    output logic                              quote_valid,
    input  logic                              quote_stall,
    output qrd_pkg::quote_word_t              quote_word,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [qrd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [qrd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import qrd_pkg::*;

    // Internal widths.
    localparam int WIDE_W  = PRICE_W + 4;
    localparam int DRIFT_W = PRICE_W + 3;
    localparam int FRAW_W  = 34;
    localparam int SHIFT_W = FRAW_W + 1;
    localparam int ADJ_W   = PROD_W - 23;
    localparam int HALF_W  = Q88_W + TICK_W - 8;
    localparam int CMP_W   = DRIFT_W + 8;
    localparam int SH_R    = (PRICE_FRAC_BITS <= 23) ? 23 - PRICE_FRAC_BITS : 0;
    localparam int SH_L    = (PRICE_FRAC_BITS > 23) ? PRICE_FRAC_BITS - 23 : 0;
    localparam int ID_X    = (ID_BITS > ID_W) ? ID_BITS : ID_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FLOW,
        ST_ADJ,
        ST_HALF,
        ST_THR,
        ST_SUM,
        ST_DONE
    } seq_state_t;

    // Configuration registers.
    logic [TICK_W-1:0]         tick_size_reg;
    logic [Q88_W-1:0]          half_spread_reg;
    logic [Q88_W-1:0]          alpha_reg;
    logic signed [PRICE_W-1:0] inv_skew_reg;
    logic [Q88_W-1:0]          reprice_thr_reg;

    // Sequencer and working registers.
    seq_state_t                state_reg;
    logic signed [PRICE_W-1:0] mid_reg;
    logic signed [FLOW_W-1:0]  flow_reg;
    logic signed [WIDE_W-1:0]  reserve_reg;
    logic signed [DRIFT_W-1:0] drift_reg;
    logic [DRIFT_W-1:0]        drift_abs_reg;
    logic [ADJ_W-1:0]          adj_reg;
    logic [HALF_W-1:0]         half_reg;
    logic signed [WIDE_W-1:0]  bid_raw_reg;
    logic signed [WIDE_W-1:0]  ask_raw_reg;
    logic                      within_reg;

    // Held quote and ids.
    logic                      live_reg;
    logic signed [PRICE_W-1:0] held_bid_reg;
    logic signed [PRICE_W-1:0] held_ask_reg;
    logic [ID_BITS-1:0]        held_bid_id_reg;
    logic [ID_BITS-1:0]        held_ask_id_reg;
    logic [ID_BITS-1:0]        id_counter_reg;

    // Output register.
    logic                      quote_valid_reg;
    quote_word_t               quote_word_reg;

    // Multiplier connections.
    logic [MUL_W-1:0]          mul_a;
    logic [MUL_W-1:0]          mul_b;
    logic [PROD_W-1:0]         prod;

    // Combinational terms.
    logic [FLOW_W-1:0]         flow_abs;
    logic signed [FRAW_W-1:0]  flow_raw;
    logic signed [SHIFT_W-1:0] flow_ext;
    logic signed [SHIFT_W-1:0] flow_scaled;
    logic signed [WIDE_W-1:0]  half_wide;
    logic signed [WIDE_W-1:0]  adj_wide;
    logic signed [WIDE_W-1:0]  bid_adj;
    logic signed [WIDE_W-1:0]  ask_adj;
    logic [CMP_W-1:0]          drift_cmp;
    logic [CMP_W-1:0]          thr_cmp;
    logic signed [PRICE_W-1:0] bid_next;
    logic signed [PRICE_W-1:0] ask_next;
    logic [ID_BITS-1:0]        ask_id_next;
    logic [ID_X-1:0]           fresh_bid_x;
    logic [ID_X-1:0]           fresh_ask_x;
    logic [ID_X-1:0]           held_bid_x;
    logic [ID_X-1:0]           held_ask_x;
    logic                      out_free;

    assign cfg_ready   = 1'b1;
    assign upd_stall   = (state_reg != ST_IDLE);
    assign quote_valid = quote_valid_reg;
    assign quote_word  = quote_word_reg;
    assign out_free    = !quote_valid_reg || !quote_stall;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_size_reg   <= TICK_W'(655);
            half_spread_reg <= Q88_W'(256);
            alpha_reg       <= '0;
            inv_skew_reg    <= '0;
            reprice_thr_reg <= Q88_W'(256);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TICK_SIZE:   tick_size_reg   <= cfg_data[TICK_W-1:0];
                CFG_HALF_SPREAD: half_spread_reg <= cfg_data[Q88_W-1:0];
                CFG_ALPHA:       alpha_reg       <= cfg_data[Q88_W-1:0];
                CFG_INV_SKEW:    inv_skew_reg    <= $signed(cfg_data[PRICE_W-1:0]);
                CFG_REPRICE_THR: reprice_thr_reg <= cfg_data[Q88_W-1:0];
                default:         ;
            endcase
        end
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_FLOW:
            begin
                mul_a = MUL_W'(alpha_reg);
                mul_b = MUL_W'(flow_abs);
            end
            ST_ADJ:
            begin
                mul_a = prod[MUL_W-1:0];
                mul_b = tick_size_reg;
            end
            ST_HALF:
            begin
                mul_a = MUL_W'(half_spread_reg);
                mul_b = tick_size_reg;
            end
            ST_THR:
            begin
                mul_a = MUL_W'(reprice_thr_reg);
                mul_b = tick_size_reg;
            end
            ST_IDLE, ST_SUM, ST_DONE:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    qrd_mul u_mul
    (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // Magnitude of the imbalance and the signed reserve shift.
    always_comb
    begin
        flow_abs    = flow_reg[FLOW_W-1] ? (~flow_reg + 1'b1) : flow_reg;
        flow_raw    = $signed({2'b00, prod[MUL_W-1:0]});
        if (flow_reg[FLOW_W-1])
        begin
            flow_raw = -flow_raw;
        end
        flow_ext    = SHIFT_W'(flow_raw);
        flow_scaled = (flow_ext <<< SH_L) >>> SH_R;
    end

    // Widening goes to the ask under positive imbalance, else to the bid.
    always_comb
    begin
        half_wide = $signed(WIDE_W'(half_reg));
        adj_wide  = $signed(WIDE_W'(adj_reg));
        if (flow_reg > 0)
        begin
            bid_adj = '0;
            ask_adj = adj_wide;
        end
        else
        begin
            bid_adj = adj_wide;
            ask_adj = '0;
        end
        drift_cmp = {drift_abs_reg, 8'b0};
        thr_cmp   = CMP_W'({prod[HALF_W+7:0], 1'b0});
    end

    // Saturate the raw quote to the signed price range.
    always_comb
    begin
        if (bid_raw_reg[WIDE_W-1:PRICE_W-1] == '0
            || bid_raw_reg[WIDE_W-1:PRICE_W-1] == '1)
        begin
            bid_next = bid_raw_reg[PRICE_W-1:0];
        end
        else
        begin
            bid_next = {bid_raw_reg[WIDE_W-1], {(PRICE_W-1){~bid_raw_reg[WIDE_W-1]}}};
        end
        if (ask_raw_reg[WIDE_W-1:PRICE_W-1] == '0
            || ask_raw_reg[WIDE_W-1:PRICE_W-1] == '1)
        begin
            ask_next = ask_raw_reg[PRICE_W-1:0];
        end
        else
        begin
            ask_next = {ask_raw_reg[WIDE_W-1], {(PRICE_W-1){~ask_raw_reg[WIDE_W-1]}}};
        end
    end

    // Ids resized to the word's id width.
    assign ask_id_next = id_counter_reg + ID_BITS'(1);
    assign fresh_bid_x = ID_X'(id_counter_reg);
    assign fresh_ask_x = ID_X'(ask_id_next);
    assign held_bid_x  = ID_X'(held_bid_id_reg);
    assign held_ask_x  = ID_X'(held_ask_id_reg);

    // Sequencer, datapath registers, held quote and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            mid_reg         <= '0;
            flow_reg        <= '0;
            reserve_reg     <= '0;
            drift_reg       <= '0;
            drift_abs_reg   <= '0;
            adj_reg         <= '0;
            half_reg        <= '0;
            bid_raw_reg     <= '0;
            ask_raw_reg     <= '0;
            within_reg      <= 1'b0;
            live_reg        <= 1'b0;
            held_bid_reg    <= '0;
            held_ask_reg    <= '0;
            held_bid_id_reg <= '0;
            held_ask_id_reg <= '0;
            id_counter_reg  <= ID_BITS'(1);
            quote_valid_reg <= 1'b0;
            quote_word_reg  <= '0;
        end
        else
        begin
            // A finished update loads the output word; otherwise it leaves when taken.
            if (state_reg == ST_DONE && out_free)
            begin
                quote_valid_reg <= 1'b1;
            end
            else if (!quote_stall)
            begin
                quote_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (upd_valid)
                    begin
                        mid_reg   <= upd_word.mid_price;
                        flow_reg  <= upd_word.flow_imbalance;
                        state_reg <= ST_FLOW;
                    end
                end
                ST_FLOW:
                begin
                    state_reg <= ST_ADJ;
                end
                ST_ADJ:
                begin
                    // Reserve price and drift from the held quote's midpoint.
                    reserve_reg <= WIDE_W'(mid_reg) - WIDE_W'(inv_skew_reg)
                                   + WIDE_W'(flow_scaled);
                    drift_reg   <= (DRIFT_W'(mid_reg) <<< 1) - DRIFT_W'(held_bid_reg)
                                   - DRIFT_W'(held_ask_reg);
                    state_reg   <= ST_HALF;
                end
                ST_HALF:
                begin
                    adj_reg       <= prod[PROD_W-1:23];
                    drift_abs_reg <= drift_reg[DRIFT_W-1] ? DRIFT_W'(-drift_reg)
                                                          : DRIFT_W'(drift_reg);
                    state_reg     <= ST_THR;
                end
                ST_THR:
                begin
                    half_reg  <= prod[HALF_W+7:8];
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    bid_raw_reg <= reserve_reg - half_wide - bid_adj;
                    ask_raw_reg <= reserve_reg + half_wide + ask_adj;
                    within_reg  <= (drift_cmp <= thr_cmp);
                    state_reg   <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                        if (live_reg && within_reg)
                        begin
                            quote_word_reg.action_kind      <= ACT_NONE;
                            quote_word_reg.bid_price_out    <= '0;
                            quote_word_reg.ask_price_out    <= '0;
                            quote_word_reg.cancelled_bid_id <= '0;
                            quote_word_reg.cancelled_ask_id <= '0;
                            quote_word_reg.fresh_bid_id     <= '0;
                            quote_word_reg.fresh_ask_id     <= '0;
                        end
                        else
                        begin
                            quote_word_reg.action_kind   <= live_reg ? ACT_REPLACE : ACT_NEW;
                            quote_word_reg.bid_price_out <= bid_next;
                            quote_word_reg.ask_price_out <= ask_next;
                            quote_word_reg.cancelled_bid_id <=
                                live_reg ? held_bid_x[ID_W-1:0] : '0;
                            quote_word_reg.cancelled_ask_id <=
                                live_reg ? held_ask_x[ID_W-1:0] : '0;
                            quote_word_reg.fresh_bid_id  <= fresh_bid_x[ID_W-1:0];
                            quote_word_reg.fresh_ask_id  <= fresh_ask_x[ID_W-1:0];
                            held_bid_reg                 <= bid_next;
                            held_ask_reg                 <= ask_next;
                            held_bid_id_reg              <= id_counter_reg;
                            held_ask_id_reg              <= ask_id_next;
                            id_counter_reg               <= id_counter_reg + ID_BITS'(2);
                            live_reg                     <= 1'b1;
                        end
                    end
                end
            endcase
        end
    end

endmodule

// File: bench/quote_reprice_decider_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for quote_reprice_decider_unit: directed corner words, then
// random market updates under several register settings, checked by a scoreboard class.
// Depends on qrd_pkg and the quote_reprice_decider_unit RTL.
module quote_reprice_decider_unit_tb;
    import qrd_pkg::*;

    localparam int     HOLD_LIMIT    = 4000;
    localparam int     SETTLE_CYCLES = 12;
    localparam int     PHASE_ITEMS   = 215;
    localparam longint PRICE_HI      = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint PRICE_LO      = -PRICE_HI - 64'sd1;
    localparam longint SPAN_CAP      = 64'sh0000_0100_0000_0000;

    // Index with no register behind it; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd5;

    // Holds the register copy and the held quote, predicts one quote word per
    // accepted update and compares it with what the block sends.
    class quote_predictor;
        bit [31:0]   tick;
        bit [15:0]   half_ticks;
        bit [15:0]   alpha;
        longint      skew;
        bit [15:0]   thr_ticks;
        bit          live;
        longint      held_bid;
        longint      held_ask;
        bit [47:0]   held_bid_id;
        bit [47:0]   held_ask_id;
        bit [47:0]   next_id;
        quote_word_t due_quotes[$];
        int          mismatches;

        function new();
            tick        = 32'd655;
            half_ticks  = 16'd256;
            alpha       = 16'd0;
            skew        = 0;
            thr_ticks   = 16'd256;
            live        = 1'b0;
            held_bid    = 0;
            held_ask    = 0;
            held_bid_id = '0;
            held_ask_id = '0;
            next_id     = 48'd1;
            mismatches  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_TICK_SIZE:   tick = data[31:0];
                CFG_HALF_SPREAD: half_ticks = data[15:0];
                CFG_ALPHA:       alpha = data[15:0];
                CFG_INV_SKEW:    skew = {{16{data[47]}}, data[47:0]};
                CFG_REPRICE_THR: thr_ticks = data[15:0];
                default: ;
            endcase
        endfunction

        function longint quote_center();
            return live ? (held_bid + held_ask) >>> 1 : 64'sd0;
        endfunction

        function longint clamp_price(longint v);
            if (v > PRICE_HI)
                return PRICE_HI;
            if (v < PRICE_LO)
                return PRICE_LO;
            return v;
        endfunction

        // Reserve price, spread and widening, then the drift decision.
        function void take_update(upd_word_t w);
            longint          mid;
            longint          flow;
            longint          reserve;
            longint          half_amt;
            longint          widen;
            longint          bid;
            longint          ask;
            longint          drift;
            longint          limit;
            longint unsigned mag_flow;
            quote_word_t     q;
            mid      = {{16{w.mid_price[47]}}, w.mid_price};
            flow     = {{48{w.flow_imbalance[15]}}, w.flow_imbalance};
            mag_flow = (flow < 0) ? -flow : flow;
            // Alpha times imbalance has 23 fraction bits; floor down to 16.
            reserve  = mid - skew + ((longint'(alpha) * flow) >>> 7);
            half_amt = longint'((64'(half_ticks) * 64'(tick)) >> 8);
            widen    = longint'((64'(alpha) * mag_flow * 64'(tick)) >> 23);
            bid      = clamp_price(reserve - half_amt - ((flow > 0) ? longint'(0) : widen));
            ask      = clamp_price(reserve + half_amt + ((flow > 0) ? widen : longint'(0)));
            q = '0;
            if (live) begin
                // Exact compare of twice the drift against twice the threshold.
                drift = 2 * mid - held_bid - held_ask;
                if (drift < 0)
                    drift = -drift;
                limit = 2 * longint'(thr_ticks) * longint'(tick);
                q.action_kind = ((drift <<< 8) > limit) ? ACT_REPLACE : ACT_NONE;
            end
            else begin
                q.action_kind = ACT_NEW;
            end
            if (q.action_kind != ACT_NONE) begin
                if (q.action_kind == ACT_REPLACE) begin
                    q.cancelled_bid_id = held_bid_id;
                    q.cancelled_ask_id = held_ask_id;
                end
                q.bid_price_out = bid[47:0];
                q.ask_price_out = ask[47:0];
                q.fresh_bid_id  = next_id;
                q.fresh_ask_id  = next_id + 48'd1;
                held_bid_id     = q.fresh_bid_id;
                held_ask_id     = q.fresh_ask_id;
                next_id         = next_id + 48'd2;
                held_bid        = bid;
                held_ask        = ask;
                live            = 1'b1;
            end
            due_quotes.push_back(q);
        endfunction

        task flag_mismatch(string what);
            $display("ERROR at %0t: %s", $time, what);
            mismatches = mismatches + 1;
        endtask

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                flag_mismatch($sformatf("%s got %h, want %h", name, got, want));
        endtask

        task check_quote(quote_word_t got);
            quote_word_t want;
            if (due_quotes.size() == 0) begin
                flag_mismatch("quote word sent with no update waiting for one");
            end
            else begin
                want = due_quotes.pop_front();
                compare_field("action_kind", got.action_kind, want.action_kind);
                compare_field("bid_price_out", got.bid_price_out, want.bid_price_out);
                compare_field("ask_price_out", got.ask_price_out, want.ask_price_out);
                compare_field("cancelled_bid_id", got.cancelled_bid_id, want.cancelled_bid_id);
                compare_field("cancelled_ask_id", got.cancelled_ask_id, want.cancelled_ask_id);
                compare_field("fresh_bid_id", got.fresh_bid_id, want.fresh_bid_id);
                compare_field("fresh_ask_id", got.fresh_ask_id, want.fresh_ask_id);
            end
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  upd_valid;
    logic                  upd_stall;
    upd_word_t             upd_word;
    logic                  quote_valid;
    logic                  quote_stall;
    quote_word_t           quote_word;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    quote_predictor quoter = new();
    int             idle_cycles = 0;
    int             stall_pct = 0;
    int             stall_left = 0;
    longint         last_mid = 0;

    quote_reprice_decider_unit dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .upd_valid   (upd_valid),
        .upd_stall   (upd_stall),
        .upd_word    (upd_word),
        .quote_valid (quote_valid),
        .quote_stall (quote_stall),
        .quote_word  (quote_word),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver stall: a new stall density after each run of random length, zero included.
    always @(negedge clk)
    begin
        if (stall_left == 0) begin
            stall_left = $urandom_range(16, 120);
            case ($urandom_range(0, 4))
                0, 1:    stall_pct = 0;
                2:       stall_pct = 25;
                3:       stall_pct = 60;
                default: stall_pct = 90;
            endcase
        end
        stall_left = stall_left - 1;
        quote_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Watch both channels at the rising edge; also the no-progress watchdog.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (upd_valid && !upd_stall)
                quoter.take_update(upd_word);
            if (quote_valid && !quote_stall)
                quoter.check_quote(quote_word);
            if ((upd_valid && !upd_stall) || (quote_valid && !quote_stall)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= HOLD_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic longint unsigned rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic upd_word_t update_of(longint mid, logic [15:0] flow);
        upd_word_t w;
        w.mid_price      = mid[47:0];
        w.flow_imbalance = flow;
        return w;
    endfunction

    // Mostly mid prices around the held quote, so both quiet and repricing
    // updates are common; the rest are wild values, extremes and repeats.
    function automatic upd_word_t next_update();
        longint          center;
        longint          span;
        longint          mid;
        longint unsigned draw;
        logic [15:0]     flow;
        int              pick;
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
            center = quoter.quote_center();
            span = (longint'(quoter.thr_ticks) * longint'(quoter.tick)) >>> 8;
            if (span < 1)
                span = 1;
            if (span > SPAN_CAP)
                span = SPAN_CAP;
            draw = rand64() % $unsigned(4 * span + 1);
            mid = center + longint'(draw) - 2 * span;
            if (mid > PRICE_HI)
                mid = PRICE_HI;
            if (mid < PRICE_LO)
                mid = PRICE_LO;
        end
        else if (pick < 86) begin
            draw = rand64();
            mid = {{16{draw[47]}}, draw[47:0]};
        end
        else if (pick < 94) begin
            case ($urandom_range(0, 4))
                0:       mid = PRICE_HI;
                1:       mid = PRICE_LO;
                2:       mid = 0;
                3:       mid = -1;
                default: mid = 1;
            endcase
        end
        else begin
            mid = last_mid;
        end
        last_mid = mid;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            flow = 16'($urandom());
        else if (pick < 75)
            flow = 16'h0000;
        else if (pick < 90) begin
            case ($urandom_range(0, 3))
                0:       flow = 16'h8000;
                1:       flow = 16'h7FFF;
                2:       flow = 16'hFFFF;
                default: flow = 16'h0001;
            endcase
        end
        else
            flow = 16'($urandom_range(0, 64) - 32);
        return update_of(mid, flow);
    endfunction

    // Present one update word and hold it until the block takes it.
    task automatic send_update(input upd_word_t w);
        upd_valid <= 1'b1;
        upd_word  <= w;
        do @(posedge clk); while (upd_stall);
        @(negedge clk);
    endtask

    // Stop sending and wait until every expected quote word has come.
    task automatic settle();
        upd_valid <= 1'b0;
        while (quoter.due_quotes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        quoter.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_settings(input logic [31:0] tick, input logic [15:0] half,
                                 input logic [15:0] alpha, input logic [47:0] skew,
                                 input logic [15:0] thr);
        settle();
        write_reg(CFG_TICK_SIZE, 48'(tick));
        write_reg(CFG_HALF_SPREAD, 48'(half));
        write_reg(CFG_ALPHA, 48'(alpha));
        write_reg(CFG_INV_SKEW, skew);
        write_reg(CFG_REPRICE_THR, 48'(thr));
    endtask

    // Random updates in bursts, with gaps, back-to-back runs and full drains.
    task automatic run_phase(input int count);
        int left;
        int burst;
        int pick;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            if (burst > left)
                burst = left;
            repeat (burst) send_update(next_update());
            left = left - burst;
            pick = $urandom_range(0, 99);
            if (pick < 3)
                settle();
            else if (pick >= 25) begin
                upd_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
        end
    endtask

    initial
    begin
        longint skew_small;
        rst_n       = 1'b0;
        upd_valid   = 1'b0;
        upd_word    = '0;
        quote_stall = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: first quote, no drift, drift exactly at the
        // threshold, one past it, then the price and imbalance extremes.
        send_update(update_of(0, 16'h0000));
        send_update(update_of(0, 16'h0000));
        send_update(update_of(655, 16'h0000));
        send_update(update_of(656, 16'h8000));
        send_update(update_of(PRICE_HI, 16'h7FFF));
        send_update(update_of(PRICE_LO, 16'h8000));
        send_update(update_of(PRICE_LO, 16'h0000));
        send_update(update_of(PRICE_HI, 16'h0001));

        // Largest tick, spread and gain with the most negative skew: the
        // quote saturates high, and a zero threshold reprices on any drift.
        load_settings(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, PRICE_LO[47:0], 16'h0000);
        send_update(update_of(PRICE_HI, 16'h7FFF));
        send_update(update_of(PRICE_LO, 16'h8000));
        send_update(update_of(0, 16'h0000));
        send_update(update_of(0, 16'h0000));
        send_update(update_of(1, 16'hFFFF));
        send_update(update_of(-1, 16'h0001));
        send_update(update_of(PRICE_HI, 16'h8000));

        // Zero tick, spread and gain with the largest skew: saturates low.
        // A write to an unused index must leave every register alone.
        load_settings(32'd0, 16'd0, 16'd0, PRICE_HI[47:0], 16'd0);
        write_reg(CFG_SPARE, 48'hA5A5_5A5A_FFFF);
        send_update(update_of(PRICE_LO, 16'h8000));
        send_update(update_of(0, 16'h0000));
        send_update(update_of(0, 16'h7FFF));
        send_update(update_of(PRICE_LO, 16'h0000));

        // Random phases, each under its own register setting.
        load_settings(32'd655, 16'd256, 16'd0, 48'd0, 16'd256);
        run_phase(PHASE_ITEMS);

        skew_small = longint'($urandom_range(0, 2000)) - 1000;
        load_settings(32'd655, 16'd512, 16'd256, 48'(skew_small), 16'd128);
        run_phase(PHASE_ITEMS);

        load_settings(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, PRICE_HI[47:0], 16'hFFFF);
        run_phase(PHASE_ITEMS);

        load_settings(32'd0, 16'd0, 16'd0, PRICE_LO[47:0], 16'd0);
        run_phase(PHASE_ITEMS);

        load_settings($urandom(), 16'($urandom()), 16'($urandom()), 48'(rand64()),
                      16'($urandom()));
        run_phase(PHASE_ITEMS);

        skew_small = longint'($urandom_range(0, 64)) - 32;
        load_settings($urandom_range(1, 64), 16'($urandom_range(0, 1024)), 16'($urandom()),
                      48'(skew_small), 16'($urandom_range(0, 512)));
        run_phase(PHASE_ITEMS);

        settle();
        if (quoter.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
